// ===== hdl/sprite_alpha_blit_rgb565_core_assert.svh =====
// assertion macros for the sprite blit core
`ifndef SPRITE_ALPHA_BLIT_RGB565_CORE_ASSERT_SVH
`define SPRITE_ALPHA_BLIT_RGB565_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define SABR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sabr assertion failed");
// next-cycle implication
`define SABR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sabr assertion failed");
`else
`define SABR_ASSERT_NOW(lbl, ante, cons)
`define SABR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/sabr_pkg.sv =====
package sabr_pkg;

  // screen size
  localparam int SCREEN_W = 240;
  localparam int SCREEN_H = 320;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POS_X         = 3'd0,
    REG_POS_Y         = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_BG_COLOR      = 3'd4
  } cfg_reg_t;

  // reciprocals for c*255/31 and c*255/63, shifted by 20
  localparam logic [15:0] EXP5_RECIP = 16'd33826;
  localparam logic [15:0] EXP6_RECIP = 16'd16645;

  // background color, raw and expanded to 8 bits per channel
  typedef struct packed {
    logic [15:0] raw;
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
  } bg_exp_t;

  // per-pixel tags carried beside the pixel
  typedef struct packed {
    logic vis;
    logic last;
  } pix_tag_t;

  // 5-bit channel to 8 bits, c*255/31
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [12:0] x;
    logic [28:0] p;
    x = {c, 8'd0} - {8'd0, c};
    p = {16'd0, x} * {13'd0, EXP5_RECIP};
    return p[27:20];
  endfunction

  // 6-bit channel to 8 bits, c*255/63
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [13:0] x;
    logic [28:0] p;
    x = {c, 8'd0} - {8'd0, c};
    p = {15'd0, x} * {13'd0, EXP6_RECIP};
    return p[27:20];
  endfunction

endpackage

// ===== hdl/sabr_if.sv =====
// pixel input channel
interface sabr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;
  modport source(output valid, output pixel_argb, input ready);
  modport sink(input valid, input pixel_argb, output ready);
endinterface

// blended pixel output channel
interface sabr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] color565;
  logic        last;
  modport source(output valid, output color565, output last, input ready);
  modport sink(input valid, input color565, input last, output ready);
endinterface

// ===== hdl/sabr_blend.sv =====
module sabr_blend (
  input  logic [31:0]            pixel_argb,
  input  sabr_pkg::bg_exp_t      bg,
  output logic [15:0]            color565
);

  // (c*a + bg*(255-a)) / 255, exact for sums up to 255*255
  function automatic logic [7:0] mix(input logic [7:0] c, input logic [7:0] bgx,
                                     input logic [7:0] a);
    logic [15:0] x;
    logic [16:0] s;
    x = ({8'd0, c} * {8'd0, a}) + ({8'd0, bgx} * {8'd0, 8'd255 - a});
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

  logic [7:0] a;
  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic [7:0] mr;
  logic [7:0] mg;
  logic [7:0] mb;

  assign a = pixel_argb[31:24];
  assign r = pixel_argb[23:16];
  assign g = pixel_argb[15:8];
  assign b = pixel_argb[7:0];

  // per-channel blend
  assign mr = mix(r, bg.r8, a);
  assign mg = mix(g, bg.g8, a);
  assign mb = mix(b, bg.b8, a);

  // transparent, opaque or blended
  always_comb begin
    if (a == 8'd0) begin
      color565 = bg.raw;
    end else if (a == 8'd255) begin
      color565 = {r[7:3], g[7:2], b[7:3]};
    end else begin
      color565 = {mr[7:3], mg[7:2], mb[7:3]};
    end
  end

endmodule

// ===== hdl/sprite_alpha_blit_rgb565_core.sv =====
// a visible pixel passes the input register and then the output register before it appears on the output
// throughput: one pixel per cycle; while a result waits the input register still
//   takes one more pixel, then input ready drops, if that pixel is visible, until the output is taken
// reset: rst is synchronous, active high; clears configuration, counters and valids
// clipped pixels and pixels of an empty sprite are consumed and give no output
module sprite_alpha_blit_rgb565_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sabr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sabr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  sabr_in_if.sink                            pix_in,
  sabr_out_if.source                         pix_out
);

  `include "sprite_alpha_blit_rgb565_core_assert.svh"

  localparam logic signed [12:0] SCR_W = 13'(sabr_pkg::SCREEN_W);
  localparam logic signed [12:0] SCR_H = 13'(sabr_pkg::SCREEN_H);

  // configuration registers
  logic signed [10:0] pos_x;
  logic signed [10:0] pos_y;
  logic [9:0]         sprite_width;
  logic [9:0]         sprite_height;
  sabr_pkg::bg_exp_t  bg;

  // source position counters
  logic [9:0] src_col;
  logic [9:0] src_row;
  logic [9:0] src_col_next;
  logic [9:0] src_row_next;

  // input stage
  logic                s1_valid;
  logic [31:0]         s1_pix;
  sabr_pkg::pix_tag_t  s1_tag;
  sabr_pkg::pix_tag_t  tag_next;

  // output register
  logic        out_valid;
  logic [15:0] out_color;
  logic        out_last;
  logic [15:0] blend_color;

  logic in_acc;
  logic s1_adv;
  logic empty;

  logic signed [12:0] sx;
  logic signed [12:0] sy;
  logic signed [12:0] lim_col;
  logic signed [12:0] lim_row;
  logic signed [12:0] wm1;
  logic signed [12:0] hm1;
  logic signed [12:0] last_col;
  logic signed [12:0] last_row;
  logic [10:0]        col_inc;
  logic [10:0]        row_inc;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= '0;
      pos_y         <= '0;
      sprite_width  <= '0;
      sprite_height <= '0;
      bg            <= '0;
    end else if (cfg_we) begin
      case (sabr_pkg::cfg_reg_t'(cfg_index))
        sabr_pkg::REG_POS_X:         pos_x <= cfg_wdata[10:0];
        sabr_pkg::REG_POS_Y:         pos_y <= cfg_wdata[10:0];
        sabr_pkg::REG_SPRITE_WIDTH:  sprite_width <= cfg_wdata[9:0];
        sabr_pkg::REG_SPRITE_HEIGHT: sprite_height <= cfg_wdata[9:0];
        sabr_pkg::REG_BG_COLOR: begin
          bg.raw   <= cfg_wdata;
          bg.r8    <= sabr_pkg::expand5(cfg_wdata[15:11]);
          bg.g8    <= sabr_pkg::expand6(cfg_wdata[10:5]);
          bg.b8    <= sabr_pkg::expand5(cfg_wdata[4:0]);
        end
        default: ;
      endcase
    end
  end

  // handshake control
  assign s1_adv       = s1_valid && (!s1_tag.vis || !out_valid || pix_out.ready);
  assign pix_in.ready = !s1_valid || s1_adv;
  assign in_acc       = pix_in.valid && pix_in.ready;
  assign empty        = (sprite_width == 10'd0) || (sprite_height == 10'd0);

  // screen position and clip test
  assign sx = 13'(pos_x) + $signed({3'd0, src_col});
  assign sy = 13'(pos_y) + $signed({3'd0, src_row});

  // last visible column and row of the clipped sprite
  assign wm1      = $signed({3'd0, sprite_width}) - 13'sd1;
  assign hm1      = $signed({3'd0, sprite_height}) - 13'sd1;
  assign lim_col  = SCR_W - 13'sd1 - 13'(pos_x);
  assign lim_row  = SCR_H - 13'sd1 - 13'(pos_y);
  assign last_col = (wm1 < lim_col) ? wm1 : lim_col;
  assign last_row = (hm1 < lim_row) ? hm1 : lim_row;

  always_comb begin
    tag_next.vis  = !empty && !sx[12] && (sx < SCR_W) && !sy[12] && (sy < SCR_H);
    tag_next.last = ($signed({3'd0, src_col}) == last_col) &&
                    ($signed({3'd0, src_row}) == last_row);
  end

  // counter advance in row-major order
  assign col_inc = {1'b0, src_col} + 11'd1;
  assign row_inc = {1'b0, src_row} + 11'd1;

  always_comb begin
    src_col_next = src_col;
    src_row_next = src_row;
    if (in_acc && !empty) begin
      if (col_inc >= {1'b0, sprite_width}) begin
        src_col_next = '0;
        if (row_inc >= {1'b0, sprite_height}) begin
          src_row_next = '0;
        end else begin
          src_row_next = row_inc[9:0];
        end
      end else begin
        src_col_next = col_inc[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col <= '0;
      src_row <= '0;
    end else begin
      src_col <= src_col_next;
      src_row <= src_row_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_in.ready) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix <= pix_in.pixel_argb;
      s1_tag <= tag_next;
    end
  end

  // color conversion
  sabr_blend u_blend (
    .pixel_argb (s1_pix),
    .bg         (bg),
    .color565   (blend_color)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_tag.vis) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_tag.vis) begin
      out_color <= blend_color;
      out_last  <= s1_tag.last;
    end
  end

  assign pix_out.valid    = out_valid;
  assign pix_out.color565 = out_color;
  assign pix_out.last     = out_last;

  // checks
  `SABR_ASSERT_NOW(a_ready_stall, !pix_in.ready, s1_valid && s1_tag.vis && out_valid && !pix_out.ready)
  `SABR_ASSERT_NEXT(a_empty_hold, in_acc && empty, $stable(src_col) && $stable(src_row))
  `SABR_ASSERT_NEXT(a_col_wrap, in_acc && !empty && (col_inc >= {1'b0, sprite_width}), src_col == 10'd0)
  `SABR_ASSERT_NEXT(a_transparent, s1_adv && s1_tag.vis && (s1_pix[31:24] == 8'd0), pix_out.valid && (pix_out.color565 == bg.raw))
  `SABR_ASSERT_NEXT(a_opaque, s1_adv && s1_tag.vis && (s1_pix[31:24] == 8'd255), pix_out.color565 == {$past(s1_pix[23:19]), $past(s1_pix[15:10]), $past(s1_pix[7:3])})

endmodule
